FILE: sv/lcdws_pkg.sv
package lcdws_pkg;

    localparam int LINE_WIDTH_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int COLUMN_W        = 5;
    localparam int COLUMN_MAX      = 31;
    localparam int MAX_STROBES     = 32;
    localparam int INIT_STEP_W     = 3;

    localparam logic [INIT_STEP_W-1:0] INIT_FIRST_STEP = 3'd0;
    localparam logic [INIT_STEP_W-1:0] INIT_BYTE_STEP  = 3'd1;
    localparam logic [INIT_STEP_W-1:0] INIT_LAST_STEP  = 3'd4;

    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CMD_WAKE_4BIT  = 8'h20;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
    localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
    localparam logic [7:0] CMD_FUNC_8BIT  = 8'h3C;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [7:0] ADDR_LINE0     = 8'h80;
    localparam logic [7:0] ADDR_LINE1     = 8'hC0;

    typedef enum logic [2:0] {
        OP_CMD  = 3'd0,
        OP_CHAR = 3'd1,
        OP_LINE = 3'd2,
        OP_PAD  = 3'd3,
        OP_INIT = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        JOB_BYTE,
        JOB_PAD,
        JOB_INIT
    } job_kind_t;

    typedef struct packed {
        job_kind_t             kind;
        logic                  rs;
        logic [7:0]            value;
        logic [COLUMN_W-1:0]   count;
    } job_t;

    function automatic logic [7:0] init_byte(input logic [INIT_STEP_W-1:0] step,
                                             input logic four);
        logic [7:0] b;
        case (step)
            3'd0:    b = CMD_WAKE_4BIT;
            3'd1:    b = CMD_DISPLAY_ON;
            3'd2:    b = four ? CMD_FUNC_4BIT : CMD_FUNC_8BIT;
            3'd3:    b = CMD_CLEAR;
            default: b = CMD_HOME;
        endcase
        return b;
    endfunction

endpackage

FILE: sv/lcdws_front.sv
module lcdws_front #(
    parameter int LINE_WIDTH = lcdws_pkg::LINE_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              four_bit_mode,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [2:0]        op,
    input  logic [7:0]        data,
    input  logic              line,
    input  logic              full,
    output logic              push,
    output lcdws_pkg::job_t   push_job
);
    import lcdws_pkg::*;

    localparam logic [COLUMN_W-1:0] EffWidth =
        (LINE_WIDTH > COLUMN_MAX) ? COLUMN_W'(COLUMN_MAX) : COLUMN_W'(LINE_WIDTH);
    localparam logic [COLUMN_W-1:0] PadCapFour = COLUMN_W'(MAX_STROBES / 2);

    logic [COLUMN_W-1:0] column_reg;
    logic [COLUMN_W-1:0] column_next;
    logic [COLUMN_W-1:0] room;
    logic [COLUMN_W-1:0] pad_n;
    logic                accept;
    logic                has_room;

    assign item_stall = full;
    assign accept     = item_valid & ~full;
    assign has_room   = column_reg < EffWidth;
    assign room       = EffWidth - column_reg;
    assign pad_n      = (four_bit_mode && (room > PadCapFour)) ? PadCapFour : room;

    always_comb
    begin
        push        = 1'b0;
        column_next = column_reg;
        push_job    = '{kind: JOB_BYTE, rs: 1'b0, value: data, count: COLUMN_W'(1)};
        if (accept)
        begin
            unique case (op_t'(op))
                OP_CMD:
                begin
                    push = 1'b1;
                end
                OP_CHAR:
                begin
                    if (has_room)
                    begin
                        push        = 1'b1;
                        push_job.rs = 1'b1;
                        column_next = column_reg + COLUMN_W'(1);
                    end
                end
                OP_LINE:
                begin
                    push           = 1'b1;
                    push_job.value = line ? ADDR_LINE1 : ADDR_LINE0;
                    column_next    = '0;
                end
                OP_PAD:
                begin
                    if (has_room)
                    begin
                        push           = 1'b1;
                        push_job.kind  = JOB_PAD;
                        push_job.rs    = 1'b1;
                        push_job.value = CHAR_SPACE;
                        push_job.count = pad_n;
                        column_next    = column_reg + pad_n;
                    end
                end
                OP_INIT:
                begin
                    push          = 1'b1;
                    push_job.kind = JOB_INIT;
                    column_next   = '0;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
        end
        else
        begin
            column_reg <= column_next;
        end
    end

endmodule

FILE: sv/lcdws_queue.sv
module lcdws_queue #(
    parameter int DEPTH = lcdws_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lcdws_pkg::job_t   push_job,
    output logic              full,
    input  logic              pop,
    output lcdws_pkg::job_t   pop_job,
    output logic              empty
);
    import lcdws_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

    job_t            mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = count_reg == CntW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: sv/lcdws_back.sv
module lcdws_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              four_bit_mode,
    input  logic              empty,
    output logic              pop,
    input  lcdws_pkg::job_t   pop_job,
    output logic              strobe_valid,
    input  logic              strobe_stall,
    output logic              rs,
    output logic [7:0]        bus,
    output logic              last
);
    import lcdws_pkg::*;

    job_t                   job_reg;
    job_t                   job_next;
    logic                   active_reg;
    logic                   active_next;
    logic [COLUMN_W-1:0]    cnt_reg;
    logic [COLUMN_W-1:0]    cnt_next;
    logic [INIT_STEP_W-1:0] step_reg;
    logic [INIT_STEP_W-1:0] step_next;
    logic                   nib_reg;
    logic                   nib_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   rs_reg;
    logic                   rs_next;
    logic [7:0]             bus_reg;
    logic [7:0]             bus_next;
    logic                   last_reg;
    logic                   last_next;

    logic [7:0]             cur_byte;
    logic                   cur_rs;
    logic                   split;
    logic                   final_byte;
    logic                   emit;

    assign pop          = ~active_reg & ~empty;
    assign emit         = active_reg & (~valid_reg | ~strobe_stall);
    assign strobe_valid = valid_reg;
    assign rs           = rs_reg;
    assign bus          = bus_reg;
    assign last         = last_reg;

    always_comb
    begin
        cur_byte   = job_reg.value;
        cur_rs     = job_reg.rs;
        split      = four_bit_mode;
        final_byte = 1'b1;
        unique case (job_reg.kind)
            JOB_BYTE:
            begin
                final_byte = 1'b1;
            end
            JOB_PAD:
            begin
                cur_byte   = CHAR_SPACE;
                cur_rs     = 1'b1;
                final_byte = cnt_reg == COLUMN_W'(1);
            end
            JOB_INIT:
            begin
                cur_byte   = init_byte(step_reg, four_bit_mode);
                cur_rs     = 1'b0;
                split      = four_bit_mode && (step_reg != INIT_FIRST_STEP);
                final_byte = step_reg == INIT_LAST_STEP;
            end
            default:
            begin
                final_byte = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        job_next    = job_reg;
        active_next = active_reg;
        cnt_next    = cnt_reg;
        step_next   = step_reg;
        nib_next    = nib_reg;
        rs_next     = rs_reg;
        bus_next    = bus_reg;
        last_next   = last_reg;
        valid_next  = strobe_stall ? valid_reg : 1'b0;

        if (pop)
        begin
            job_next    = pop_job;
            active_next = 1'b1;
            cnt_next    = pop_job.count;
            step_next   = four_bit_mode ? INIT_FIRST_STEP : INIT_BYTE_STEP;
            nib_next    = 1'b0;
        end
        else if (emit)
        begin
            valid_next = 1'b1;
            rs_next    = cur_rs;
            if (split)
            begin
                bus_next  = nib_reg ? {cur_byte[3:0], 4'h0} : {cur_byte[7:4], 4'h0};
                last_next = final_byte & nib_reg;
            end
            else
            begin
                bus_next  = cur_byte;
                last_next = final_byte;
            end

            if (split && !nib_reg)
            begin
                nib_next = 1'b1;
            end
            else
            begin
                nib_next = 1'b0;
                if (final_byte)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    cnt_next  = cnt_reg - COLUMN_W'(1);
                    step_next = step_reg + INIT_STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            cnt_reg    <= '0;
            step_reg   <= '0;
            nib_reg    <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
            cnt_reg    <= cnt_next;
            step_reg   <= step_next;
            nib_reg    <= nib_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        rs_reg   <= rs_next;
        bus_reg  <= bus_next;
        last_reg <= last_next;
    end

endmodule

FILE: sv/char_lcd_write_sequencer_top.sv
// The first strobe of a transaction passes through the job queue, the back-end job
// register and the output register. The back end emits one strobe per cycle while
// strobe_stall is low, and loads the next job only once the current one (1 to 32 strobes) is done.
// The job queue (two entries by default) lets the front accept while the back end is busy.
// Reset (rst_n low, async): column, mode register, queue and output valid are cleared.
module char_lcd_write_sequencer_top #(
    parameter int LINE_WIDTH  = lcdws_pkg::LINE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = lcdws_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic       wr_data,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [2:0] op,
    input  logic [7:0] data,
    input  logic       line,
    output logic       strobe_valid,
    input  logic       strobe_stall,
    output logic       rs,
    output logic [7:0] bus,
    output logic       last
);
    import lcdws_pkg::*;

    logic four_bit_mode_reg;
    logic push;
    job_t push_job;
    logic full;
    logic pop;
    job_t pop_job;
    logic empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_bit_mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            four_bit_mode_reg <= wr_data;
        end
    end

    lcdws_front #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .four_bit_mode (four_bit_mode_reg),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .op            (op),
        .data          (data),
        .line          (line),
        .full          (full),
        .push          (push),
        .push_job      (push_job)
    );

    lcdws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (empty)
    );

    lcdws_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .four_bit_mode (four_bit_mode_reg),
        .empty         (empty),
        .pop           (pop),
        .pop_job       (pop_job),
        .strobe_valid  (strobe_valid),
        .strobe_stall  (strobe_stall),
        .rs            (rs),
        .bus           (bus),
        .last          (last)
    );

endmodule

FILE: tb/lcd_strobe_checker.sv
`timescale 1ns / 100ps
module lcd_strobe_checker #(
    parameter int LINE_WIDTH = lcdws_pkg::LINE_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic       wr_data,
    input  logic       item_valid,
    input  logic       item_stall,
    input  logic [2:0] op,
    input  logic [7:0] data,
    input  logic       line,
    input  logic       strobe_valid,
    input  logic       strobe_stall,
    input  logic       rs,
    input  logic [7:0] bus,
    input  logic       last,
    output int         mismatches,
    output int         pending,
    output int         strobes_checked
);
    import lcdws_pkg::*;

    localparam int WIDTH_EFF = (LINE_WIDTH > COLUMN_MAX) ? COLUMN_MAX : LINE_WIDTH;

    typedef struct packed {
        logic       rs;
        logic [7:0] bus;
        logic       last;
    } strobe_t;

    strobe_t             expected_strobes[$];
    strobe_t             request_strobes[$];
    strobe_t             got;
    logic                nibble_mode;
    logic [COLUMN_W-1:0] column;

    function void put_strobe(input logic rs_v, input logic [7:0] b);
        if (request_strobes.size() < MAX_STROBES)
            request_strobes.push_back('{rs_v, b, 1'b0});
    endfunction

    function void put_byte(input logic rs_v, input logic [7:0] b);
        if (nibble_mode)
        begin
            put_strobe(rs_v, {b[7:4], 4'h0});
            put_strobe(rs_v, {b[3:0], 4'h0});
        end
        else
        begin
            put_strobe(rs_v, b);
        end
    endfunction

    function void expand_request(input logic [2:0] op_v, input logic [7:0] d, input logic ln);
        int per;
        per = nibble_mode ? 2 : 1;
        request_strobes.delete();
        case (op_v)
            OP_CMD:
                put_byte(1'b0, d);
            OP_CHAR:
                if (column < WIDTH_EFF)
                begin
                    put_byte(1'b1, d);
                    column = column + 1'b1;
                end
            OP_LINE:
            begin
                put_byte(1'b0, ln ? ADDR_LINE1 : ADDR_LINE0);
                column = '0;
            end
            OP_PAD:
                while (column < WIDTH_EFF && request_strobes.size() + per <= MAX_STROBES)
                begin
                    put_byte(1'b1, CHAR_SPACE);
                    column = column + 1'b1;
                end
            OP_INIT:
            begin
                if (nibble_mode)
                    put_strobe(1'b0, CMD_WAKE_4BIT);
                put_byte(1'b0, CMD_DISPLAY_ON);
                put_byte(1'b0, nibble_mode ? CMD_FUNC_4BIT : CMD_FUNC_8BIT);
                put_byte(1'b0, CMD_CLEAR);
                put_byte(1'b0, CMD_HOME);
                column = '0;
            end
            default:
                ;
        endcase
        if (request_strobes.size() > 0)
            request_strobes[request_strobes.size() - 1].last = 1'b1;
        foreach (request_strobes[i])
            expected_strobes.push_back(request_strobes[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_strobes.delete();
            nibble_mode     = 1'b0;
            column          = '0;
            mismatches      = 0;
            pending         = 0;
            strobes_checked = 0;
        end
        else
        begin
            if (strobe_valid && !strobe_stall)
            begin
                strobes_checked++;
                if (expected_strobes.size() == 0)
                begin
                    $error("unexpected strobe: rs=%0b bus=%02h last=%0b", rs, bus, last);
                    mismatches++;
                end
                else
                begin
                    got = expected_strobes.pop_front();
                    if (rs !== got.rs)
                    begin
                        $error("rs: expected %0b, actual %0b", got.rs, rs);
                        mismatches++;
                    end
                    if (bus !== got.bus)
                    begin
                        $error("bus: expected %02h, actual %02h", got.bus, bus);
                        mismatches++;
                    end
                    if (last !== got.last)
                    begin
                        $error("last: expected %0b, actual %0b", got.last, last);
                        mismatches++;
                    end
                end
            end
            if (wr_en)
                nibble_mode = wr_data;
            if (item_valid && !item_stall)
                expand_request(op, data, line);
            pending = expected_strobes.size();
        end
    end

endmodule

FILE: tb/tb_char_lcd_write_sequencer_top.sv
`timescale 1ns / 100ps
module tb_char_lcd_write_sequencer_top;

    import lcdws_pkg::*;

    localparam int LINE_W       = 16;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 160;

    localparam logic [2:0] OP_RSVD_LO  = 3'd5;
    localparam logic [2:0] OP_RSVD_MID = 3'd6;
    localparam logic [2:0] OP_RSVD_HI  = 3'd7;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       wr_en        = 1'b0;
    logic       wr_data      = 1'b0;
    logic       item_valid   = 1'b0;
    logic [2:0] op           = 3'd0;
    logic [7:0] data         = 8'd0;
    logic       line         = 1'b0;
    logic       strobe_stall = 1'b0;
    logic       item_stall;
    logic       strobe_valid;
    logic       rs;
    logic [7:0] bus;
    logic       last;

    bit hold_req = 1'b0;
    bit quiet    = 1'b0;

    int mismatches;
    int pending;
    int strobes_checked;
    int requests_sent = 0;

    char_lcd_write_sequencer_top #(
        .LINE_WIDTH(LINE_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_data     (wr_data),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .op          (op),
        .data        (data),
        .line        (line),
        .strobe_valid(strobe_valid),
        .strobe_stall(strobe_stall),
        .rs          (rs),
        .bus         (bus),
        .last        (last)
    );

    lcd_strobe_checker #(
        .LINE_WIDTH(LINE_W)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_data        (wr_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .op             (op),
        .data           (data),
        .line           (line),
        .strobe_valid   (strobe_valid),
        .strobe_stall   (strobe_stall),
        .rs             (rs),
        .bus            (bus),
        .last           (last),
        .mismatches     (mismatches),
        .pending        (pending),
        .strobes_checked(strobes_checked)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("[char_lcd_write_sequencer_top] ERROR");
        $finish;
    end

    // output side: random stall bursts, one long hold on request, none when quiet
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                strobe_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                strobe_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                strobe_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                strobe_stall <= 1'b0;
            end
            else
            begin
                strobe_stall <= 1'b0;
            end
        end
    end

    task automatic send(input logic [2:0] o, input logic [7:0] d, input logic l);
        item_valid <= 1'b1;
        op         <= o;
        data       <= d;
        line       <= l;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        if (o <= OP_INIT)
            requests_sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic drain();
        do
        begin
            while (pending != 0) @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
        while (pending != 0);
    endtask

    task automatic set_mode(input logic m);
        item_valid <= 1'b0;
        drain();
        wr_en   <= 1'b1;
        wr_data <= m;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic text_line(input int max_chars);
        send(OP_LINE, 8'($urandom), 1'($urandom));
        repeat ($urandom_range(0, max_chars))
            send(OP_CHAR, 8'($urandom), 1'($urandom));
        if ($urandom_range(0, 3) != 0)
            send(OP_PAD, 8'($urandom), 1'($urandom));
    endtask

    task automatic run_phase(input int target);
        int start;
        start = requests_sent;
        while (requests_sent - start < target)
        begin
            case ($urandom_range(0, 9))
                0:       send(OP_INIT, 8'($urandom), 1'($urandom));
                1:       send(OP_CMD, 8'($urandom), 1'($urandom));
                2, 3:    send(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
                default: text_line(20);
            endcase
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 8-bit bus
        set_mode(1'b0);
        send(OP_INIT, 8'h00, 1'b0);
        send(OP_CMD, 8'h00, 1'b0);
        send(OP_CMD, 8'hFF, 1'b1);
        send(OP_LINE, 8'h00, 1'b0);
        send(OP_CHAR, 8'hFF, 1'b0);
        send(OP_CHAR, 8'h00, 1'b1);
        send(OP_PAD, 8'h00, 1'b0);
        send(OP_CHAR, 8'h41, 1'b0);
        send(OP_PAD, 8'hFF, 1'b1);
        send(OP_LINE, 8'hFF, 1'b1);
        send(OP_PAD, 8'h00, 1'b0);
        send(OP_RSVD_LO, 8'hFF, 1'b1);
        send(OP_RSVD_HI, 8'h00, 1'b0);
        send(OP_CMD, 8'hA5, 1'b1);

        // 4-bit bus
        set_mode(1'b1);
        send(OP_INIT, 8'hFF, 1'b1);
        send(OP_LINE, 8'h5A, 1'b0);
        send(OP_CHAR, 8'h5A, 1'b0);
        send(OP_CHAR, 8'hC3, 1'b1);
        send(OP_PAD, 8'h00, 1'b0);
        send(OP_LINE, 8'h00, 1'b1);
        send(OP_PAD, 8'h00, 1'b0);
        send(OP_CMD, 8'hF0, 1'b0);
        send(OP_RSVD_MID, 8'h0F, 1'b0);

        // long output hold while requests keep coming
        hold_req = 1'b1;
        send(OP_LINE, 8'h00, 1'b0);
        send(OP_PAD, 8'h00, 1'b0);
        send(OP_LINE, 8'h00, 1'b1);
        send(OP_PAD, 8'h00, 1'b0);
        send(OP_INIT, 8'h00, 1'b0);
        send(OP_CMD, 8'h3C, 1'b0);
        run_phase(12);

        set_mode(1'b0);
        run_phase(15);
        set_mode(1'b1);
        run_phase(12);
        set_mode(1'b0);
        quiet = 1'b1;
        run_phase(15);

        item_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests, %0d strobes checked, over 8-bit and 4-bit bus modes,",
                 requests_sent, strobes_checked);
        $display("with full lines, padding, reserved ops and one long output hold.");
        if (mismatches == 0 && pending == 0)
            $display("[char_lcd_write_sequencer_top] OK");
        else
            $display("[char_lcd_write_sequencer_top] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
sv/lcdws_pkg.sv
sv/lcdws_front.sv
sv/lcdws_queue.sv
sv/lcdws_back.sv
sv/char_lcd_write_sequencer_top.sv
tb/lcd_strobe_checker.sv
tb/tb_char_lcd_write_sequencer_top.sv
